// File: design/gwf_pkg.sv
// gwf_pkg: shared types, constants and helper functions of the grid wall follower
// used by every module of the block; depends on nothing

package gwf_pkg;

   localparam int GRID_ROWS = 8;
   localparam int GRID_COLS = 8;

   // coordinates are 3 bits wide, so only the first eight rows and columns are reachable
   localparam int ROWS_EFF   = (GRID_ROWS < 8) ? GRID_ROWS : 8;
   localparam int COLS_EFF   = (GRID_COLS < 8) ? GRID_COLS : 8;
   localparam int CELL_COUNT = ROWS_EFF * COLS_EFF;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_WALL = 2'd1;
   localparam logic [1:0] KIND_EXIT = 2'd2;
   localparam logic [1:0] KIND_BOT  = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   localparam logic STATUS_EXIT  = 1'b0;
   localparam logic STATUS_LIMIT = 1'b1;

   localparam logic [1:0] CSR_START_ROW     = 2'd0;
   localparam logic [1:0] CSR_START_COL     = 2'd1;
   localparam logic [1:0] CSR_START_HEADING = 2'd2;
   localparam logic [1:0] CSR_STEP_LIMIT    = 2'd3;

   localparam logic [1:0] HEAD_NORTH = 2'd0;
   localparam logic [1:0] HEAD_EAST  = 2'd1;
   localparam logic [1:0] HEAD_SOUTH = 2'd2;
   localparam logic [1:0] HEAD_WEST  = 2'd3;

   localparam logic [1:0] TRY_LEFT    = 2'd0;
   localparam logic [1:0] TRY_FORWARD = 2'd1;
   localparam logic [1:0] TRY_RIGHT   = 2'd2;

   typedef struct packed {
      logic       op;
      logic [2:0] cell_row;
      logic [2:0] cell_col;
      logic [1:0] cell_kind;
   } req_type;

   typedef struct packed {
      logic [2:0]  final_row;
      logic [2:0]  final_col;
      logic [1:0]  final_heading;
      logic [15:0] steps_taken;
      logic        run_status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  start_row;
      logic [2:0]  start_col;
      logic [1:0]  start_heading;
      logic [15:0] step_limit;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]        dir;
      logic [2:0]        row;
      logic [2:0]        col;
      logic              on_grid;
      logic [ADDR_W-1:0] addr;
   } probe_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_PROBE,
      ST_CHECK,
      ST_VACATE,
      ST_OCCUPY
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [2:0] row,
                                                    input logic [2:0] col);
      logic [ADDR_W+3:0] full;
      full = (ADDR_W+4)'(row) * (ADDR_W+4)'(COLS_EFF) + (ADDR_W+4)'(col);
      return full[ADDR_W-1:0];
   endfunction

   function automatic logic cell_on_grid(input logic [2:0] row, input logic [2:0] col);
      return ({1'b0, row} < 4'(ROWS_EFF)) && ({1'b0, col} < 4'(COLS_EFF));
   endfunction

   // left, forward, right relative to the heading
   function automatic logic [1:0] try_offset(input logic [1:0] try_idx);
      logic [1:0] offs;
      case (try_idx)
         TRY_LEFT:    offs = 2'd3;
         TRY_FORWARD: offs = 2'd0;
         TRY_RIGHT:   offs = 2'd1;
         default:     offs = 2'd0;
      endcase
      return offs;
   endfunction

endpackage

// File: design/gwf_grid_ram.sv
// gwf_grid_ram: single-port grid cell store with registered read and per-cell valid bits
// depends on gwf_pkg

module gwf_grid_ram (
   input  logic                clock,
   input  logic                reset,
   input  gwf_pkg::mem_req_type mem_req,
   output logic [1:0]          rd_kind
);

   logic [1:0]                    mem [gwf_pkg::CELL_COUNT];
   logic [gwf_pkg::CELL_COUNT-1:0] vld_ff;
   logic [1:0]                    rd_data_ff;
   logic                          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_req.we) begin
            vld_ff[mem_req.addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[mem_req.addr];
      end
   end

   // never-written cells read as open
   assign rd_kind = rd_vld_ff ? rd_data_ff : gwf_pkg::KIND_OPEN;

endmodule

// File: design/gwf_probe.sv
// gwf_probe: shared neighbor unit, turns position, heading and try index into a cell address
// depends on gwf_pkg

module gwf_probe (
   input  logic [2:0]         row,
   input  logic [2:0]         col,
   input  logic [1:0]         heading,
   input  logic [1:0]         try_idx,
   output gwf_pkg::probe_type probe
);

   logic [1:0] dir;
   logic [3:0] nrow;
   logic [3:0] ncol;
   logic [3:0] drow;
   logic [3:0] dcol;

   always_comb begin
      dir  = heading + gwf_pkg::try_offset(try_idx);
      drow = 4'd0;
      dcol = 4'd0;
      case (dir)
         gwf_pkg::HEAD_NORTH: drow = 4'hF;
         gwf_pkg::HEAD_EAST:  dcol = 4'h1;
         gwf_pkg::HEAD_SOUTH: drow = 4'h1;
         gwf_pkg::HEAD_WEST:  dcol = 4'hF;
         default: begin
            drow = 4'd0;
            dcol = 4'd0;
         end
      endcase
      // a step below zero wraps to a value that fails the bound compare
      nrow = {1'b0, row} + drow;
      ncol = {1'b0, col} + dcol;

      probe.dir     = dir;
      probe.row     = nrow[2:0];
      probe.col     = ncol[2:0];
      probe.on_grid = (nrow < 4'(gwf_pkg::ROWS_EFF)) && (ncol < 4'(gwf_pkg::COLS_EFF));
      probe.addr    = gwf_pkg::cell_addr(nrow[2:0], ncol[2:0]);
   end

endmodule

// File: design/gwf_seq.sv
// gwf_seq: sequencer of the wall follower, walks the bot one try at a time through the grid store
// depends on gwf_pkg, gwf_probe

module gwf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  gwf_pkg::req_type     req_item,
   input  gwf_pkg::cfg_type     cfg,
   input  logic [1:0]           rd_kind,
   output gwf_pkg::mem_req_type mem_req,
   output logic                 busy,
   output logic                 rsp_valid,
   output gwf_pkg::rsp_type     rsp_item
);

   gwf_pkg::state_type state_ff, state_in;
   logic [2:0]         row_ff, row_in;
   logic [2:0]         col_ff, col_in;
   logic [1:0]         head_ff, head_in;
   logic [15:0]        step_ff, step_in;
   logic [1:0]         try_ff, try_in;
   logic               found_ff, found_in;
   logic [2:0]         nrow_ff, nrow_in;
   logic [2:0]         ncol_ff, ncol_in;
   logic [1:0]         ndir_ff, ndir_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gwf_pkg::rsp_type   rsp_ff, rsp_in;

   gwf_pkg::probe_type probe;
   logic               passable;
   logic               run_done;

   gwf_probe u_probe (
      .row     (row_ff),
      .col     (col_ff),
      .heading (head_ff),
      .try_idx (try_ff),
      .probe   (probe)
   );

   assign passable = probe.on_grid &&
                     ((rd_kind == gwf_pkg::KIND_OPEN) || (rd_kind == gwf_pkg::KIND_EXIT));
   assign run_done = (step_ff == cfg.step_limit) || found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwf_pkg::ST_IDLE: begin
            if (start && (req_item.op == gwf_pkg::OP_RUN)) begin
               state_in = gwf_pkg::ST_TEST;
            end
         end
         gwf_pkg::ST_TEST: begin
            state_in = run_done ? gwf_pkg::ST_IDLE : gwf_pkg::ST_PROBE;
         end
         gwf_pkg::ST_PROBE: state_in = gwf_pkg::ST_CHECK;
         gwf_pkg::ST_CHECK: begin
            if (passable) begin
               state_in = gwf_pkg::ST_VACATE;
            end else if (try_ff == gwf_pkg::TRY_RIGHT) begin
               state_in = gwf_pkg::ST_TEST;
            end else begin
               state_in = gwf_pkg::ST_PROBE;
            end
         end
         gwf_pkg::ST_VACATE: state_in = gwf_pkg::ST_OCCUPY;
         gwf_pkg::ST_OCCUPY: state_in = gwf_pkg::ST_TEST;
         default:            state_in = gwf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem_req       = '0;
      mem_req.addr  = probe.addr;
      row_in        = row_ff;
      col_in        = col_ff;
      head_in       = head_ff;
      step_in       = step_ff;
      try_in        = try_ff;
      found_in      = found_ff;
      nrow_in       = nrow_ff;
      ncol_in       = ncol_ff;
      ndir_in       = ndir_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         gwf_pkg::ST_IDLE: begin
            mem_req.addr  = gwf_pkg::cell_addr(req_item.cell_row, req_item.cell_col);
            mem_req.wdata = req_item.cell_kind;
            if (start) begin
               if (req_item.op == gwf_pkg::OP_WRITE) begin
                  mem_req.we = gwf_pkg::cell_on_grid(req_item.cell_row, req_item.cell_col);
               end else begin
                  row_in   = cfg.start_row;
                  col_in   = cfg.start_col;
                  head_in  = cfg.start_heading;
                  step_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         gwf_pkg::ST_TEST: begin
            try_in = gwf_pkg::TRY_LEFT;
            if (run_done) begin
               rsp_valid_in         = 1'b1;
               rsp_in.final_row     = row_ff;
               rsp_in.final_col     = col_ff;
               rsp_in.final_heading = head_ff;
               rsp_in.steps_taken   = step_ff;
               rsp_in.run_status    = found_ff ? gwf_pkg::STATUS_EXIT : gwf_pkg::STATUS_LIMIT;
            end
         end
         gwf_pkg::ST_PROBE: begin
            mem_req.addr = probe.addr;
         end
         gwf_pkg::ST_CHECK: begin
            if (passable) begin
               nrow_in  = probe.row;
               ncol_in  = probe.col;
               ndir_in  = probe.dir;
               found_in = (rd_kind == gwf_pkg::KIND_EXIT);
            end else if (try_ff == gwf_pkg::TRY_RIGHT) begin
               head_in = head_ff + 2'd2;
               step_in = step_ff + 16'd1;
            end else begin
               try_in = try_ff + 2'd1;
            end
         end
         gwf_pkg::ST_VACATE: begin
            mem_req.we    = gwf_pkg::cell_on_grid(row_ff, col_ff);
            mem_req.addr  = gwf_pkg::cell_addr(row_ff, col_ff);
            mem_req.wdata = gwf_pkg::KIND_OPEN;
         end
         gwf_pkg::ST_OCCUPY: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = gwf_pkg::cell_addr(nrow_ff, ncol_ff);
            mem_req.wdata = gwf_pkg::KIND_BOT;
            row_in        = nrow_ff;
            col_in        = ncol_ff;
            head_in       = ndir_ff;
            step_in       = step_ff + 16'd1;
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gwf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         head_ff      <= '0;
         step_ff      <= '0;
         try_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         head_ff      <= head_in;
         step_ff      <= step_in;
         try_ff       <= try_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      nrow_ff <= nrow_in;
      ncol_ff <= ncol_in;
      ndir_ff <= ndir_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != gwf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: design/grid_wall_follower.sv
// grid_wall_follower: top level, configuration registers around the sequencer and grid store
// depends on gwf_pkg, gwf_seq, gwf_grid_ram
//
// A write item (op 0) is taken while busy stays low; it leaves no result. A run
// item (op 1) raises busy and walks the bot by the left-hand rule through the single-port grid
// store, one neighbor read per look: a step is a decision state, a probe and a check state for
// each of up to three looks, and a vacate and an occupy write for a move. The result then shows
// on rsp_item for exactly one cycle with rsp_valid high, as busy falls; the receiver has to take
// it then, since the block cannot hold it. The grid reads as all open after reset, with no
// clearing pass.

module grid_wall_follower (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gwf_pkg::req_type req_item,
   output logic             rsp_valid,
   output gwf_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   gwf_pkg::cfg_type     cfg_ff, cfg_in;
   gwf_pkg::mem_req_type mem_req;
   logic [1:0]           rd_kind;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gwf_pkg::CSR_START_ROW:     cfg_in.start_row     = csr_wdata[2:0];
            gwf_pkg::CSR_START_COL:     cfg_in.start_col     = csr_wdata[2:0];
            gwf_pkg::CSR_START_HEADING: cfg_in.start_heading = csr_wdata[1:0];
            gwf_pkg::CSR_STEP_LIMIT:    cfg_in.step_limit    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_row     <= 3'd1;
         cfg_ff.start_col     <= 3'd1;
         cfg_ff.start_heading <= gwf_pkg::HEAD_EAST;
         cfg_ff.step_limit    <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gwf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .rd_kind   (rd_kind),
      .mem_req   (mem_req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   gwf_grid_ram u_grid (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_kind (rd_kind)
   );

endmodule

// File: design/gwf_checker.sv
// gwf_checker: port-level assertions of the grid wall follower, bound to the top level
// depends on gwf_pkg, grid_wall_follower

module gwf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input gwf_pkg::req_type req_item,
   input logic             rsp_valid,
   input gwf_pkg::rsp_type rsp_item
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.op == gwf_pkg::OP_RUN)) |=> busy)
      else $error("run transfer did not raise busy");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.op == gwf_pkg::OP_WRITE)) |=> (!busy && !rsp_valid))
      else $error("cell write caused busy or a result");

   a_busy_fall_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("run ended without a result");

   a_exit_needs_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.run_status == gwf_pkg::STATUS_EXIT)) |->
      (rsp_item.steps_taken != 16'd0))
      else $error("exit reported with zero steps");

endmodule

bind grid_wall_follower gwf_checker u_gwf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// File: tb/sv/grid_wall_follower_test.sv
// grid_wall_follower_test: self-checking testbench for the left-hand wall follower
// drives cell writes, solver runs and register writes, predicts every run result and compares
// depends on gwf_pkg and grid_wall_follower

module grid_wall_follower_test;

   localparam int RANDOM_ITEMS   = 750;
   localparam int QUIET_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 2_400_000;
   localparam int DIRECTED_ROWS  = 33;

   typedef enum bit {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       csr_idx;
      logic [15:0]      csr_val;
      gwf_pkg::req_type item;
      bit               typed;
      gwf_pkg::rsp_type result;
   } plan_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   gwf_pkg::req_type req_item  = '0;
   logic             rsp_valid;
   gwf_pkg::rsp_type rsp_item;
   logic             csr_we    = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [15:0]      csr_wdata = '0;

   logic [1:0]       grid_model [gwf_pkg::CELL_COUNT];
   logic [2:0]       cfg_row     = 3'd1;
   logic [2:0]       cfg_col     = 3'd1;
   logic [1:0]       cfg_heading = gwf_pkg::HEAD_EAST;
   logic [15:0]      cfg_limit   = 16'd100;
   gwf_pkg::rsp_type expected_results [$];
   int               mismatch_count = 0;

   plan_row_type plan [DIRECTED_ROWS] = '{
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd7, 3'd7, gwf_pkg::KIND_BOT}, 1'b1,
        {3'd1, 3'd1, gwf_pkg::HEAD_EAST, 16'd100, gwf_pkg::STATUS_LIMIT}},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd0, 3'd0, gwf_pkg::KIND_OPEN}, 1'b1,
        {3'd1, 3'd1, gwf_pkg::HEAD_EAST, 16'd0, gwf_pkg::STATUS_LIMIT}},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'd1, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_ROW, 16'hFFF8, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_COL, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_HEADING, 16'(gwf_pkg::HEAD_NORTH), '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd5, 3'd2, gwf_pkg::KIND_WALL}, 1'b1,
        {3'd0, 3'd1, gwf_pkg::HEAD_EAST, 16'd1, gwf_pkg::STATUS_LIMIT}},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd0, 3'd2, gwf_pkg::KIND_EXIT}, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_COL, 16'd1, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_HEADING, 16'(gwf_pkg::HEAD_EAST), '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd2, 3'd5, gwf_pkg::KIND_EXIT}, 1'b1,
        {3'd0, 3'd2, gwf_pkg::HEAD_EAST, 16'd1, gwf_pkg::STATUS_EXIT}},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd7, 3'd6, gwf_pkg::KIND_WALL}, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd6, 3'd7, gwf_pkg::KIND_BOT}, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'd3, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_ROW, 16'd7, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_COL, 16'd7, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_HEADING, 16'(gwf_pkg::HEAD_SOUTH), '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd7, 3'd0, gwf_pkg::KIND_OPEN}, 1'b1,
        {3'd7, 3'd7, gwf_pkg::HEAD_NORTH, 16'd3, gwf_pkg::STATUS_LIMIT}},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'd2, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_HEADING, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd0, 3'd7, gwf_pkg::KIND_BOT}, 1'b1,
        {3'd7, 3'd7, gwf_pkg::HEAD_WEST, 16'd2, gwf_pkg::STATUS_LIMIT}},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd7, 3'd6, gwf_pkg::KIND_OPEN}, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd3, 3'd4, gwf_pkg::KIND_EXIT}, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd5, 3'd5, gwf_pkg::KIND_WALL}, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd4, 3'd0, gwf_pkg::KIND_BOT}, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_STEP_LIMIT, 16'd60, '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd3, 3'd3, gwf_pkg::KIND_EXIT}, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_WRITE, 3'd0, 3'd0, gwf_pkg::KIND_WALL}, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_ROW, 16'd2, '0, 1'b0, '0},
      '{ROW_CSR, gwf_pkg::CSR_START_COL, 16'd3, '0, 1'b0, '0},
      '{ROW_ITEM, gwf_pkg::CSR_START_ROW, 16'd0,
        {gwf_pkg::OP_RUN, 3'd4, 3'd6, gwf_pkg::KIND_WALL}, 1'b0, '0}
   };

   grid_wall_follower dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cells off the grid read as walls
   function automatic logic [1:0] cell_at(input int r, input int c);
      if (r < 0 || c < 0 || r >= gwf_pkg::ROWS_EFF || c >= gwf_pkg::COLS_EFF) begin
         return gwf_pkg::KIND_WALL;
      end
      return grid_model[r * gwf_pkg::COLS_EFF + c];
   endfunction

   function automatic void set_cell(input int r, input int c, input logic [1:0] kind);
      if (r >= 0 && c >= 0 && r < gwf_pkg::ROWS_EFF && c < gwf_pkg::COLS_EFF) begin
         grid_model[r * gwf_pkg::COLS_EFF + c] = kind;
      end
   endfunction

   function automatic gwf_pkg::rsp_type walk_bot();
      int               r;
      int               c;
      int               nr;
      int               nc;
      logic [1:0]       h;
      logic [1:0]       d;
      logic [1:0]       kind;
      logic [15:0]      steps;
      bit               found;
      bit               moved;
      gwf_pkg::rsp_type res;
      r = int'(cfg_row);
      c = int'(cfg_col);
      h = cfg_heading;
      steps = '0;
      found = 1'b0;
      while (steps != cfg_limit && !found) begin
         moved = 1'b0;
         // left, then forward, then right
         for (int k = 0; k < 3 && !moved; k++) begin
            d = h - 2'd1 + 2'(k);
            nr = r + ((d == gwf_pkg::HEAD_NORTH) ? -1 : (d == gwf_pkg::HEAD_SOUTH) ? 1 : 0);
            nc = c + ((d == gwf_pkg::HEAD_EAST) ? 1 : (d == gwf_pkg::HEAD_WEST) ? -1 : 0);
            kind = cell_at(nr, nc);
            if (kind == gwf_pkg::KIND_OPEN || kind == gwf_pkg::KIND_EXIT) begin
               set_cell(r, c, gwf_pkg::KIND_OPEN);
               r = nr;
               c = nc;
               set_cell(r, c, gwf_pkg::KIND_BOT);
               h = d;
               moved = 1'b1;
               found = (kind == gwf_pkg::KIND_EXIT);
            end
         end
         if (!moved) h = h + 2'd2;
         steps = steps + 16'd1;
      end
      res.final_row     = 3'(r);
      res.final_col     = 3'(c);
      res.final_heading = h;
      res.steps_taken   = steps;
      res.run_status    = found ? gwf_pkg::STATUS_EXIT : gwf_pkg::STATUS_LIMIT;
      return res;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic drive_item(input gwf_pkg::req_type item, input bit typed,
                             input gwf_pkg::rsp_type typed_result);
      gwf_pkg::rsp_type predicted;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      if (item.op == gwf_pkg::OP_RUN) begin
         predicted = walk_bot();
         expected_results.push_back(typed ? typed_result : predicted);
      end else begin
         set_cell(int'(item.cell_row), int'(item.cell_col), item.cell_kind);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         gwf_pkg::CSR_START_ROW:     cfg_row = val[2:0];
         gwf_pkg::CSR_START_COL:     cfg_col = val[2:0];
         gwf_pkg::CSR_START_HEADING: cfg_heading = val[1:0];
         gwf_pkg::CSR_STEP_LIMIT:    cfg_limit = val;
         default:                    ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every run has reported, then let the block settle
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic idle_gap(input bit quiet);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      gwf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: expected none actual %0d/%0d/%0d/%0d/%0d",
                     $time, rsp_item.final_row, rsp_item.final_col, rsp_item.final_heading,
                     rsp_item.steps_taken, rsp_item.run_status);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("final_row", int'(want.final_row), int'(rsp_item.final_row));
            compare_field("final_col", int'(want.final_col), int'(rsp_item.final_col));
            compare_field("final_heading", int'(want.final_heading),
                          int'(rsp_item.final_heading));
            compare_field("steps_taken", int'(want.steps_taken),
                          int'(rsp_item.steps_taken));
            compare_field("run_status", int'(want.run_status), int'(rsp_item.run_status));
         end
      end
   end

   // any transfer on a port restarts the count
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_we) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int               random_items;
      int               runs;
      int               writes;
      int               pick;
      logic [15:0]      value;
      gwf_pkg::req_type item;
      foreach (grid_model[j]) grid_model[j] = gwf_pkg::KIND_OPEN;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_results();
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            drive_item(plan[i].item, plan[i].typed, plan[i].result);
            idle_gap(1'b0);
         end
      end

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         // register writes only outside the quiet tail
         if (random_items <= RANDOM_ITEMS - QUIET_ITEMS) begin
            drain_results();
            for (int idx = 0; idx < 4; idx++) begin
               if ($urandom_range(0, 1) == 1) begin
                  value = 16'($urandom);
                  if (2'(idx) == gwf_pkg::CSR_STEP_LIMIT) begin
                     pick = $urandom_range(0, 39);
                     if (pick == 0) value = 16'd0;
                     else if (pick < 5) value = 16'($urandom_range(65, 500));
                     else value = 16'($urandom_range(1, 64));
                  end
                  write_csr(2'(idx), value);
               end
            end
         end
         runs = $urandom_range(1, 4);
         repeat (runs) begin
            writes = $urandom_range(0, 12);
            repeat (writes) begin
               item.op       = gwf_pkg::OP_WRITE;
               item.cell_row = 3'($urandom);
               item.cell_col = 3'($urandom);
               pick = $urandom_range(0, 19);
               if (pick < 7) item.cell_kind = gwf_pkg::KIND_WALL;
               else if (pick < 15) item.cell_kind = gwf_pkg::KIND_OPEN;
               else if (pick < 17) item.cell_kind = gwf_pkg::KIND_EXIT;
               else item.cell_kind = gwf_pkg::KIND_BOT;
               drive_item(item, 1'b0, '0);
               random_items++;
               idle_gap(random_items > RANDOM_ITEMS - QUIET_ITEMS);
            end
            item = gwf_pkg::req_type'(9'($urandom));
            item.op = gwf_pkg::OP_RUN;
            drive_item(item, 1'b0, '0);
            random_items++;
            idle_gap(random_items > RANDOM_ITEMS - QUIET_ITEMS);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: grid_wall_follower.f
design/gwf_pkg.sv
design/gwf_grid_ram.sv
design/gwf_probe.sv
design/gwf_seq.sv
design/grid_wall_follower.sv
design/gwf_checker.sv
tb/sv/grid_wall_follower_test.sv
